// ===== hw/rtl/mre_pkg.sv =====
// Shared types and register codes for the mask run extractor.
package mre_pkg;

    // Field widths
    localparam int unsigned DIM_W  = 12;
    localparam int unsigned LINE_W = 13;
    localparam int unsigned END_W  = 13;
    localparam int unsigned IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SCAN_MODE     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_QUERY_LENGTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TARGET_LENGTH = 2'd2;

    // Scan order codes
    localparam logic SCAN_ROW  = 1'b0;
    localparam logic SCAN_DIAG = 1'b1;

    // One emitted run bound, last field (line) in the lowest bits
    typedef struct packed {
        logic [END_W-1:0]  run_end;
        logic [DIM_W-1:0]  run_first;
        logic [LINE_W-1:0] line;
    } t_bound;

endpackage

// ===== hw/rtl/mask_run_extractor_row_or_diagonal_core.sv =====
// Run bound extractor over a row-major or anti-diagonal stream of mask cells.
// A bound is registered into the output buffer from the cell word that ends its run.
// Throughput: one cell word per cycle while s_axis_tready is high; the cell walk and
// the run tracker are updated combinationally from registered state, and a two-entry
// output buffer keeps s_axis_tready high while one bound waits downstream.
// Reset: synchronous, active low; clears config and scan state (diagonal length to one).
module mask_run_extractor_row_or_diagonal_core
    import mre_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4095
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Cell words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [0] inside_req, [7:1] zero
    // Bound words
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // [12:0] line, [24:13] run_first,
                                              // [37:25] run_end, [39:38] zero
    // Configuration writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data
);

    localparam logic [16:0] MaxDim = 17'(MAX_DIM);

    // Configuration registers
    logic              r_scan_mode;
    logic [DIM_W-1:0]  r_qlen;
    logic [DIM_W-1:0]  r_tlen;

    // Scan state
    logic [LINE_W-1:0] r_line,      n_line;
    logic [DIM_W-1:0]  r_cell,      n_cell;
    logic [END_W-1:0]  r_dlen,      n_dlen;
    logic [DIM_W-1:0]  r_dleft,     n_dleft;
    logic              r_run_open,  n_run_open;
    logic [DIM_W-1:0]  r_run_start, n_run_start;

    // Output buffer
    logic              r_out_valid;
    t_bound            r_out;
    logic              r_skid_valid;
    t_bound            r_skid;

    logic              cfg_wr;
    logic              cfg_hit;
    logic              accept;
    logic              cell_in;
    logic              diag;
    logic [DIM_W-1:0]  q_c;
    logic [DIM_W-1:0]  t_c;
    logic [LINE_W-1:0] qt_sum;
    logic [DIM_W-1:0]  qt_min;
    logic [END_W-1:0]  right;
    logic              last;
    logic              close_clear;
    logic              emit;
    logic [DIM_W-1:0]  start_mid;
    logic [LINE_W-1:0] line_max;
    logic [LINE_W-1:0] line_nx;
    logic [LINE_W-1:0] tail;
    logic [LINE_W-1:0] len_min;
    logic [DIM_W-1:0]  left_nx;
    t_bound            bound;

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign cfg_hit       = cfg_wr && (i_cfg_index == CFG_SCAN_MODE ||
                                      i_cfg_index == CFG_QUERY_LENGTH ||
                                      i_cfg_index == CFG_TARGET_LENGTH);
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cell_in       = s_axis_tdata[0];
    assign diag          = (r_scan_mode == SCAN_DIAG);

    // Clamp dimensions
    assign q_c = ({5'd0, r_qlen} > MaxDim) ? MaxDim[DIM_W-1:0] : r_qlen;
    assign t_c = ({5'd0, r_tlen} > MaxDim) ? MaxDim[DIM_W-1:0] : r_tlen;
    assign qt_sum = {1'b0, q_c} + {1'b0, t_c};
    assign qt_min = (q_c < t_c) ? q_c : t_c;

    // End of current line
    assign right = {1'b0, r_dleft} + r_dlen;
    assign last  = diag ? (({1'b0, r_cell} + 13'd1) >= right) : (r_cell >= t_c);

    // Run tracker
    assign close_clear = r_run_open && !cell_in;
    assign start_mid   = (!r_run_open && cell_in) ? r_cell : r_run_start;
    assign emit        = close_clear || (last && cell_in);

    always_comb begin
        bound.line = r_line;
        if (close_clear) begin
            bound.run_first = r_run_start;
            bound.run_end   = {1'b0, r_cell};
        end else begin
            bound.run_first = start_mid;
            bound.run_end   = diag ? right : ({1'b0, t_c} + 13'd1);
        end
    end

    // Next line and its diagonal geometry
    assign line_max = diag ? qt_sum : {1'b0, q_c};
    assign line_nx  = (r_line >= line_max) ? '0 : r_line + 13'd1;
    assign left_nx  = (line_nx > {1'b0, t_c}) ? DIM_W'(line_nx - {1'b0, t_c}) : '0;
    assign tail     = qt_sum - line_nx;

    always_comb begin
        len_min = line_nx;
        if ({1'b0, qt_min} < len_min) begin
            len_min = {1'b0, qt_min};
        end
        if (tail < len_min) begin
            len_min = tail;
        end
    end

    // Scan state next value
    always_comb begin
        n_line      = r_line;
        n_cell      = r_cell;
        n_dlen      = r_dlen;
        n_dleft     = r_dleft;
        n_run_open  = r_run_open;
        n_run_start = r_run_start;
        if (cfg_hit) begin
            n_line      = '0;
            n_cell      = '0;
            n_dlen      = 13'd1;
            n_dleft     = '0;
            n_run_open  = 1'b0;
            n_run_start = '0;
        end else if (accept) begin
            n_run_start = start_mid;
            if (!last) begin
                n_cell     = r_cell + 12'd1;
                n_run_open = cell_in;
            end else begin
                n_run_open = 1'b0;
                n_line     = line_nx;
                if (diag) begin
                    n_dleft = left_nx;
                    n_dlen  = len_min + 13'd1;
                    n_cell  = left_nx;
                end else begin
                    n_cell  = '0;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode <= SCAN_ROW;
            r_qlen      <= '0;
            r_tlen      <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SCAN_MODE:     r_scan_mode <= i_cfg_data[0];
                CFG_QUERY_LENGTH:  r_qlen      <= i_cfg_data;
                CFG_TARGET_LENGTH: r_tlen      <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= '0;
            r_cell      <= '0;
            r_dlen      <= 13'd1;
            r_dleft     <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
        end else begin
            r_line      <= n_line;
            r_cell      <= n_cell;
            r_dlen      <= n_dlen;
            r_dleft     <= n_dleft;
            r_run_open  <= n_run_open;
            r_run_start <= n_run_start;
        end
    end

    // Output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept && emit;
            end
        end else if (accept && emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept && emit) begin
                r_out <= bound;
            end
        end else if (accept && emit) begin
            r_skid <= bound;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

endmodule

// ===== hw/rtl/mre_checker.sv =====
// Port-level checks for the mask run extractor, bound to the top level.
module mre_checker
    import mre_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    t_bound out_w;
    assign out_w = m_axis_tdata[37:0];

    // Reset empties the output side and opens the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

    // A stalled bound word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("bound word changed under stall");

    // Input only backs up while a bound is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
        else $error("input stalled with no waiting bound");

    // Every run is non-empty
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_w.run_end > {1'b0, out_w.run_first})
        else $error("run end not beyond run start");

endmodule

bind mask_run_extractor_row_or_diagonal_core mre_checker u_mre_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
